### hdl/est_pkg.sv
// ----------------------------------------------------------------------------
// Event subscription table package
// Shared types, codes and sizes for the subscription table and its cells.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int OP_W    = 2;
  localparam int EVENT_W = 32;
  localparam int TAG_W   = 16;
  localparam int PAY_W   = 32;
  localparam int COUNT_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_SUB     = 2'd1,
    OP_UNSUB   = 2'd2,
    OP_PUBLISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // One subscriber slot as it travels along the cell row.
  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [TAG_W-1:0]   tag;
  } slot_t;

endpackage

### hdl/est_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per request.
// ----------------------------------------------------------------------------
interface est_req_if;
  import est_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [EVENT_W-1:0] event_num;
  logic [TAG_W-1:0]   handler_tag;
  logic [PAY_W-1:0]   payload;

  modport source (output valid, operation, event_num, handler_tag, payload, input ready);
  modport sink   (input valid, operation, event_num, handler_tag, payload, output ready);
endinterface

### hdl/est_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries status, delivery and count results.
// ----------------------------------------------------------------------------
interface est_res_if;
  import est_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic               status;
  logic [TAG_W-1:0]   delivered_tag;
  logic [PAY_W-1:0]   delivered_payload;
  logic [COUNT_W-1:0] match_count;
  logic               last;

  modport source (output valid, kind, status, delivered_tag, delivered_payload,
                  match_count, last, input ready);
  modport sink   (input valid, kind, status, delivered_tag, delivered_payload,
                  match_count, last, output ready);
endinterface

### hdl/est_cell.sv
// ----------------------------------------------------------------------------
// Subscription cell
// Holds one slot and hands it to its lower neighbor on every shift.
// ----------------------------------------------------------------------------
module est_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  est_pkg::slot_t slot_in,
  output est_pkg::slot_t slot_out
);
  import est_pkg::*;

  logic [EVENT_W-1:0] ev_r;
  logic [TAG_W-1:0]   tag_r;

  // The tag marks occupancy, so it alone is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (shift_en) begin
      tag_r <= slot_in.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ev_r <= slot_in.ev;
    end
  end

  assign slot_out.ev  = ev_r;
  assign slot_out.tag = tag_r;

endmodule

### hdl/est_ctrl.sv
// ----------------------------------------------------------------------------
// Subscription table controller
// Sequences one request over a full rotation of the cell row and owns the
// result register.
// ----------------------------------------------------------------------------
module est_ctrl #(
  parameter int SLOT_COUNT = est_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  est_req_if.sink        in_req,
  est_res_if.source      out_res,
  input  est_pkg::slot_t head_slot,
  output est_pkg::slot_t wb_slot,
  output logic           shift_en
);
  import est_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [EVENT_W-1:0] ev_r;
  logic [TAG_W-1:0]   tag_r;
  logic [PAY_W-1:0]   pay_r;
  logic [IDX_W-1:0]   idx_r;
  logic               done_r;
  logic [COUNT_W-1:0] match_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic               out_status_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [PAY_W-1:0]   out_pay_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  logic advance;
  logic accept;
  logic take;
  logic hit_pub;
  logic load_dlv;
  logic load_fin;
  logic in_ready;

  assign advance = !out_valid_r || out_res.ready;
  assign accept  = in_req.valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (shift_en && (idx_r == IDX_LAST)) state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (advance) state_nxt = accept ? ST_SCAN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and the write-back into the tail of the cell row.
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    load_fin = 1'b0;
    take     = 1'b0;
    wb_slot  = head_slot;
    hit_pub  = (op_r == OP_PUBLISH) && (head_slot.tag != '0) && (head_slot.ev == ev_r);
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  shift_en = advance;
      ST_FINAL: begin
        in_ready = advance;
        load_fin = advance;
      end
      default: ;
    endcase
    case (op_r)
      OP_CLEAR: wb_slot.tag = '0;
      OP_SUB: begin
        if (!done_r && (head_slot.tag == '0)) begin
          take        = 1'b1;
          wb_slot.ev  = ev_r;
          wb_slot.tag = tag_r;
        end
      end
      OP_UNSUB: begin
        if (!done_r && (head_slot.tag == tag_r)) begin
          take        = 1'b1;
          wb_slot.tag = '0;
        end
      end
      default: ;
    endcase
    load_dlv = shift_en && hit_pub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_req.operation);
      ev_r    <= in_req.event_num;
      tag_r   <= in_req.handler_tag;
      pay_r   <= in_req.payload;
      idx_r   <= '0;
      done_r  <= 1'b0;
      match_r <= '0;
    end else if (shift_en) begin
      idx_r  <= idx_r + 1'b1;
      done_r <= done_r | take;
      if (hit_pub && (match_r != COUNT_MAX)) begin
        match_r <= match_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_dlv || load_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_dlv) begin
      out_kind_r   <= 1'b1;
      out_status_r <= 1'b0;
      out_tag_r    <= head_slot.tag;
      out_pay_r    <= pay_r;
      out_count_r  <= '0;
      out_last_r   <= 1'b0;
    end else if (load_fin) begin
      out_kind_r   <= 1'b0;
      out_status_r <= ((op_r == OP_SUB) || (op_r == OP_UNSUB)) && !done_r;
      out_tag_r    <= '0;
      out_pay_r    <= '0;
      out_count_r  <= (op_r == OP_PUBLISH) ? match_r : '0;
      out_last_r   <= 1'b1;
    end
  end

  assign in_req.ready              = in_ready;
  assign out_res.valid             = out_valid_r;
  assign out_res.kind              = out_kind_r;
  assign out_res.status            = out_status_r;
  assign out_res.delivered_tag     = out_tag_r;
  assign out_res.delivered_payload = out_pay_r;
  assign out_res.match_count       = out_count_r;
  assign out_res.last              = out_last_r;

`ifndef SYNTHESIS
  // A held delivery always belongs to a publish request.
  a_dlv_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> (op_r == OP_PUBLISH))
    else $error("delivery result held for a non-publish request");

  // The rotation position freezes while the result side is stalled.
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !advance) |=> $stable(idx_r))
    else $error("rotation moved during a result stall");

  // At most one match per visited slot.
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(match_r) <= 32'(idx_r)))
    else $error("match count ran ahead of the scan position");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == ST_IDLE) && !out_valid_r)
    else $error("block not idle after reset");
`endif

endmodule

### hdl/event_subscription_table.sv
// ----------------------------------------------------------------------------
// Event subscription table
// Table of subscriber slots kept in a rotating row of cells.
// ----------------------------------------------------------------------------
// Usage: a request on in_req carries an operation (clear, subscribe,
// unsubscribe or publish) with an event number, a handler tag and a payload.
// Results leave on out_res. Clear, subscribe and unsubscribe give one status
// result. Publish gives one delivery result per occupied slot whose event
// matches, in slot order, then a count result; the final result has last set.
// Every request takes the slot row through one full rotation, one slot
// passing the controller per cycle while out_res is not stalled, and then
// one final result. With no stall a new request is taken in the cycle the
// previous final result is loaded. A delivery is registered into out_res
// as its slot shifts out of the head cell. When the receiver holds ready
// low with a result waiting, the rotation stops in place and resumes when
// the result is taken; nothing is lost. Reset empties every slot and
// leaves no result pending. Event numbers are not cleared; they are only
// read from occupied slots.
// ----------------------------------------------------------------------------
module event_subscription_table #(
  parameter int SLOT_COUNT = est_pkg::SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  est_req_if.sink   in_req,
  est_res_if.source out_res
);
  import est_pkg::*;

  // chain[i] is the slot held by cell i; chain[SLOT_COUNT] is the slot the
  // controller writes back into the tail of the row.
  slot_t chain [SLOT_COUNT+1];
  logic  shift_en;

  est_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .head_slot (chain[0]),
    .wb_slot   (chain[SLOT_COUNT]),
    .shift_en  (shift_en)
  );

  // Each cell takes its upper neighbor's slot on every shift, so after a full
  // rotation every slot is back in its own cell.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    est_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .slot_in  (chain[i+1]),
      .slot_out (chain[i])
    );
  end

endmodule
